FILE: sv/nhwcnc_pkg.sv
// Shared widths, register indexes, step codes and control structs of the NHWC to NC1HWC0 generator.
package nhwcnc_pkg;

  // Offset arithmetic width; offsets wrap modulo 2**OFFSET_BITS.
  localparam int OFFSET_BITS = 48;
  localparam int LO_BITS     = OFFSET_BITS / 2;
  localparam int HI_BITS     = OFFSET_BITS - LO_BITS;

  // Largest channel block taken; larger settings are clamped to it.
  localparam int MAX_BLOCK   = 64;
  localparam int DIM_HW_MAX  = 4096;

  // Configuration register widths.
  localparam int N_W    = 16;
  localparam int H_W    = 13;
  localparam int W_W    = 13;
  localparam int C_W    = 16;
  localparam int C0_W   = 7;
  localparam int EB_W   = 4;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Position counter widths.
  localparam int BAT_W  = 16;
  localparam int BLK_W  = 16;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 12;
  localparam int LANE_W = $clog2(MAX_BLOCK);

  // Multiply-add operand widths.
  localparam int K_W    = 16;
  localparam int CIDX_W = BLK_W + C0_W;
  localparam int A_W    = CIDX_W;

  // Ceiling division of the channel count by the block size.
  localparam int DIV_W  = C_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DIM_N      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_H      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_W      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_C0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES = 3'd5;

  // Multiply-add steps of the offset computation.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_BLOCK = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ROW   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_COL   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LANE  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SCALE = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              div_start;
    logic              load;
    logic              mul_lo;
    logic              mul_hi;
    logic [STEP_W-1:0] step;
    logic              emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic c1_valid;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

FILE: sv/nhwcnc_div.sv
// Iterative restoring divider, one quotient bit per cycle, for the channel block count.
module nhwcnc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nhwcnc_pkg::DIV_W-1:0]  dividend,
  input  logic [nhwcnc_pkg::C0_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [nhwcnc_pkg::DIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(nhwcnc_pkg::DIV_W + 1);

  logic [CNT_W-1:0]                count;
  logic [nhwcnc_pkg::C0_W-1:0]     rem;
  logic [nhwcnc_pkg::DIV_W-1:0]    quot;
  logic [nhwcnc_pkg::C0_W:0]       rem_sh;
  logic [nhwcnc_pkg::C0_W:0]       rem_sub;
  logic                            fits;

  assign rem_sh  = {rem, quot[nhwcnc_pkg::DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(nhwcnc_pkg::DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The remainder stays below the divisor, so it fits the divisor's width.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= rem_sub[nhwcnc_pkg::C0_W-1:0];
      quot <= {quot[nhwcnc_pkg::DIV_W-2:0], fits};
    end
  end

  assign quotient = quot;

endmodule

FILE: sv/nhwcnc_ctrl.sv
// Controller state machine that sequences divide, load, multiply-add steps and result hand-off.
module nhwcnc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nhwcnc_pkg::sts_t   sts,
  output nhwcnc_pkg::cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_LOAD   = 6'b000100,
    S_MUL_LO = 6'b001000,
    S_MUL_HI = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [nhwcnc_pkg::STEP_W-1:0]   step;
  logic [nhwcnc_pkg::STEP_W-1:0]   step_next;

  always_comb begin
    state_next    = state;
    step_next     = step;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.go) begin
            if (sts.c1_valid) begin
              state_next = S_LOAD;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (sts.c1_valid) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        step_next  = nhwcnc_pkg::STEP_BLOCK;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        if (step == nhwcnc_pkg::STEP_SCALE) begin
          state_next = S_EMIT;
        end else begin
          step_next  = step + nhwcnc_pkg::STEP_W'(1);
          state_next = S_MUL_LO;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= nhwcnc_pkg::STEP_BLOCK;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

FILE: sv/nhwcnc_dp.sv
// Datapath: configuration, position counters, divider, offset multiply-add and result register.
module nhwcnc_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [nhwcnc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nhwcnc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                  restart,
  input  nhwcnc_pkg::cmd_t                      cmd,
  output nhwcnc_pkg::sts_t                      sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [nhwcnc_pkg::OFFSET_BITS-1:0]    dst_byte_off,
  output logic [nhwcnc_pkg::OFFSET_BITS-1:0]    src_byte_off,
  output logic                                  pad,
  output logic                                  last
);

  localparam int OB    = nhwcnc_pkg::OFFSET_BITS;
  localparam int LO    = nhwcnc_pkg::LO_BITS;
  localparam int HI    = nhwcnc_pkg::HI_BITS;
  localparam int KW    = nhwcnc_pkg::K_W;
  localparam int AW    = nhwcnc_pkg::A_W;
  localparam int PL_W  = LO + KW;
  localparam int C0_W  = nhwcnc_pkg::C0_W;
  localparam int H_W   = nhwcnc_pkg::H_W;
  localparam int W_W   = nhwcnc_pkg::W_W;
  localparam int CI_W  = nhwcnc_pkg::CIDX_W;
  localparam int DIV_W = nhwcnc_pkg::DIV_W;
  localparam int BLK_X = nhwcnc_pkg::BLK_W + 1;
  localparam int BAT_X = nhwcnc_pkg::BAT_W + 1;

  // Configuration registers.
  logic [nhwcnc_pkg::N_W-1:0]   dim_n;
  logic [H_W-1:0]               dim_h;
  logic [W_W-1:0]               dim_w;
  logic [nhwcnc_pkg::C_W-1:0]   dim_c;
  logic [C0_W-1:0]              block_c0;
  logic [nhwcnc_pkg::EB_W-1:0]  elem_bytes;

  // Position of the next element.
  logic [nhwcnc_pkg::BAT_W-1:0]  batch_count;
  logic [nhwcnc_pkg::BLK_W-1:0]  block_count;
  logic [nhwcnc_pkg::ROW_W-1:0]  row_count;
  logic [nhwcnc_pkg::COL_W-1:0]  col_count;
  logic [nhwcnc_pkg::LANE_W-1:0] lane_count;
  logic                          active;

  logic [nhwcnc_pkg::BLK_W-1:0]  c1;
  logic                          c1_valid;
  logic                          div_busy;
  logic                          div_done;
  logic [DIV_W-1:0]              div_quot;

  logic [C0_W-1:0] c0_eff;
  logic [H_W-1:0]  h_eff;
  logic [W_W-1:0]  w_eff;
  logic            empty;

  logic [CI_W-1:0] cidx;
  logic [OB-1:0]   acc_d;
  logic [OB-1:0]   acc_s;
  logic [PL_W-1:0] p_lo_d;
  logic [PL_W-1:0] p_lo_s;
  logic [HI-1:0]   hi_d;
  logic [HI-1:0]   hi_s;
  logic [KW-1:0]   k_d;
  logic [KW-1:0]   k_s;
  logic [AW-1:0]   a_d;
  logic [AW-1:0]   a_s;

  logic e_lane, e_col, e_row, e_blk, e_bat;
  logic last_now, pad_now;

  assign c0_eff = (block_c0 > C0_W'(nhwcnc_pkg::MAX_BLOCK)) ?
                  C0_W'(nhwcnc_pkg::MAX_BLOCK) : block_c0;
  assign h_eff  = (dim_h > H_W'(nhwcnc_pkg::DIM_HW_MAX)) ?
                  H_W'(nhwcnc_pkg::DIM_HW_MAX) : dim_h;
  assign w_eff  = (dim_w > W_W'(nhwcnc_pkg::DIM_HW_MAX)) ?
                  W_W'(nhwcnc_pkg::DIM_HW_MAX) : dim_w;
  assign empty  = (dim_n == '0) || (dim_h == '0) || (dim_w == '0) || (dim_c == '0) ||
                  (c0_eff == '0) || (elem_bytes == '0);

  // A counter counts as at its end once its successor reaches the limit.
  assign e_lane = (C0_W'(lane_count) + C0_W'(1)) >= c0_eff;
  assign e_col  = (W_W'(col_count) + W_W'(1)) >= w_eff;
  assign e_row  = (H_W'(row_count) + H_W'(1)) >= h_eff;
  assign e_blk  = (BLK_X'(block_count) + BLK_X'(1)) >= BLK_X'(c1);
  assign e_bat  = (BAT_X'(batch_count) + BAT_X'(1)) >= BAT_X'(dim_n);
  assign last_now = e_lane && e_col && e_row && e_blk && e_bat;
  assign pad_now  = cidx >= CI_W'(dim_c);

  assign sts.go       = (restart || active) && !empty;
  assign sts.c1_valid = c1_valid;
  assign sts.div_busy = div_busy;
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_n      <= nhwcnc_pkg::N_W'(1);
      dim_h      <= H_W'(1);
      dim_w      <= W_W'(1);
      dim_c      <= nhwcnc_pkg::C_W'(1);
      block_c0   <= C0_W'(16);
      elem_bytes <= nhwcnc_pkg::EB_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        nhwcnc_pkg::REG_DIM_N:      dim_n      <= cfg_data[nhwcnc_pkg::N_W-1:0];
        nhwcnc_pkg::REG_DIM_H:      dim_h      <= cfg_data[H_W-1:0];
        nhwcnc_pkg::REG_DIM_W:      dim_w      <= cfg_data[W_W-1:0];
        nhwcnc_pkg::REG_DIM_C:      dim_c      <= cfg_data[nhwcnc_pkg::C_W-1:0];
        nhwcnc_pkg::REG_BLOCK_C0:   block_c0   <= cfg_data[C0_W-1:0];
        nhwcnc_pkg::REG_ELEM_BYTES: elem_bytes <= cfg_data[nhwcnc_pkg::EB_W-1:0];
        default: ;
      endcase
    end
  end

  // The block count follows the channel count and block size; a write to either
  // makes it stale until the divider has run again.
  nhwcnc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (DIV_W'(dim_c) + DIV_W'(c0_eff) - DIV_W'(1)),
    .divisor  (c0_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (cfg_we && (cfg_index == nhwcnc_pkg::REG_DIM_C ||
                            cfg_index == nhwcnc_pkg::REG_BLOCK_C0)) begin
      c1_valid <= 1'b0;
    end else if (div_done) begin
      c1_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      c1 <= div_quot[nhwcnc_pkg::BLK_W-1:0];
    end
  end

  // Position counters: cleared by a restart, advanced when a result is emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count <= '0;
      block_count <= '0;
      row_count   <= '0;
      col_count   <= '0;
      lane_count  <= '0;
      active      <= 1'b0;
    end else if (cmd.accept) begin
      if (restart) begin
        batch_count <= '0;
        block_count <= '0;
        row_count   <= '0;
        col_count   <= '0;
        lane_count  <= '0;
      end
      active <= sts.go;
    end else if (cmd.emit) begin
      if (last_now) begin
        batch_count <= '0;
        block_count <= '0;
        row_count   <= '0;
        col_count   <= '0;
        lane_count  <= '0;
        active      <= 1'b0;
      end else if (!e_lane) begin
        lane_count <= lane_count + nhwcnc_pkg::LANE_W'(1);
      end else begin
        lane_count <= '0;
        if (!e_col) begin
          col_count <= col_count + nhwcnc_pkg::COL_W'(1);
        end else begin
          col_count <= '0;
          if (!e_row) begin
            row_count <= row_count + nhwcnc_pkg::ROW_W'(1);
          end else begin
            row_count <= '0;
            if (!e_blk) begin
              block_count <= block_count + nhwcnc_pkg::BLK_W'(1);
            end else begin
              block_count <= '0;
              batch_count <= batch_count + nhwcnc_pkg::BAT_W'(1);
            end
          end
        end
      end
    end
  end

  // Operands of each step: acc = acc * k + a, for destination and source.
  always_comb begin
    case (cmd.step)
      nhwcnc_pkg::STEP_BLOCK: begin
        k_d = c1;                   a_d = AW'(block_count);
        k_s = KW'(1);               a_s = '0;
      end
      nhwcnc_pkg::STEP_ROW: begin
        k_d = KW'(h_eff);           a_d = AW'(row_count);
        k_s = KW'(h_eff);           a_s = AW'(row_count);
      end
      nhwcnc_pkg::STEP_COL: begin
        k_d = KW'(w_eff);           a_d = AW'(col_count);
        k_s = KW'(w_eff);           a_s = AW'(col_count);
      end
      nhwcnc_pkg::STEP_LANE: begin
        k_d = KW'(c0_eff);          a_d = AW'(lane_count);
        k_s = KW'(dim_c);           a_s = AW'(cidx);
      end
      nhwcnc_pkg::STEP_SCALE: begin
        k_d = KW'(elem_bytes);      a_d = '0;
        k_s = KW'(elem_bytes);      a_s = '0;
      end
      default: begin
        k_d = '0;                   a_d = '0;
        k_s = '0;                   a_s = '0;
      end
    endcase
  end

  // Only the low HI_BITS bits of the upper partial product survive the wrap.
  assign hi_d = HI'(acc_d[OB-1:LO]) * HI'(k_d);
  assign hi_s = HI'(acc_s[OB-1:LO]) * HI'(k_s);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cidx  <= CI_W'(block_count) * CI_W'(c0_eff) + CI_W'(lane_count);
      acc_d <= OB'(batch_count);
      acc_s <= OB'(batch_count);
    end else if (cmd.mul_lo) begin
      p_lo_d <= PL_W'(acc_d[LO-1:0]) * PL_W'(k_d);
      p_lo_s <= PL_W'(acc_s[LO-1:0]) * PL_W'(k_s);
    end else if (cmd.mul_hi) begin
      acc_d <= {hi_d, {LO{1'b0}}} + OB'(p_lo_d) + OB'(a_d);
      acc_s <= {hi_s, {LO{1'b0}}} + OB'(p_lo_s) + OB'(a_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dst_byte_off <= acc_d;
      src_byte_off <= pad_now ? '0 : acc_s;
      pad          <= pad_now;
      last         <= last_now;
    end
  end

endmodule

FILE: sv/nhwc_to_nc1hwc0_address_gen_top.sv
// Top level of the NHWC to NC1HWC0 address generator: controller, datapath and checks.
// An item with a result runs the load, the five multiply-add steps and the hand-off, which waits
// while an untaken result is held; out_valid is registered from it. An item with no result (empty
// tensor, or advance with no pass running) is done in the cycle it is taken. A new item is taken
// only after the previous hand-off; the first after a write to dim_c or block_c0 also runs the
// bit-serial divider. Synchronous active-high reset restores the register defaults and idles.
module nhwc_to_nc1hwc0_address_gen_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [nhwcnc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nhwcnc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [nhwcnc_pkg::OFFSET_BITS-1:0]    dst_byte_off,
  output logic [nhwcnc_pkg::OFFSET_BITS-1:0]    src_byte_off,
  output logic                                  pad,
  output logic                                  last
);

  nhwcnc_pkg::cmd_t cmd;
  nhwcnc_pkg::sts_t sts;

  // The controller accepts an item only when idle, then walks the datapath through the
  // divide (when the block count is stale), the operand load, the multiply-add steps and
  // the hand-off into the result register. The result register lets a new item be taken
  // while the previous result still waits downstream.
  nhwcnc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the position counters and both offset
  // accumulators; a result is written only when the output register is free.
  nhwcnc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart      (restart),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dst_byte_off (dst_byte_off),
    .src_byte_off (src_byte_off),
    .pad          (pad),
    .last         (last)
  );

  // A new result never overwrites one that is still waiting to be taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result written over a pending result");

  // The output becomes valid only through an emit from the controller.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid raised without an emit");

  // No item is taken while the divider is still deriving the block count.
  assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> !in_ready)
    else $error("input ready while the divider is busy");

endmodule
